/* sv/world_to_screen_projection_macros.svh */
`ifndef WORLD_TO_SCREEN_PROJECTION_MACROS_SVH
`define WORLD_TO_SCREEN_PROJECTION_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define WSP_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define WSP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/wsp_pkg.sv */
package wsp_pkg;

    localparam int LANES  = 3;
    localparam int CLIP_W = 50;
    localparam int ABS_W  = 49;
    localparam int QUO_W  = 48;
    localparam int WIDE_W = 68;

    localparam logic [QUO_W-1:0] NDC_CAP = {1'b1, {(QUO_W-1){1'b0}}};

    typedef enum logic [2:0] {
        REG_ROW_X      = 3'd0,
        REG_ROW_Y      = 3'd1,
        REG_ROW_Z      = 3'd2,
        REG_TRANS_LOW  = 3'd3,
        REG_TRANS_HIGH = 3'd4,
        REG_VIEWPORT   = 3'd5
    } reg_index_t;

    typedef struct packed {
        logic [LANES-1:0] neg;
        logic             w_zero;
    } div_side_t;

    typedef struct packed {
        logic [LANES-1:0][ABS_W-1:0] num;
        logic [ABS_W-1:0]            den;
        div_side_t                   side;
    } div_in_t;

    typedef struct packed {
        logic [LANES-1:0][QUO_W-1:0] quo;
        logic [LANES-1:0]            ovf;
        div_side_t                   side;
    } div_out_t;

    function automatic logic [31:0] sat32(input logic signed [WIDE_W-1:0] v);
        logic [31:0] r;
        if (v > $signed({{(WIDE_W-31){1'b0}}, {31{1'b1}}})) begin
            r = 32'h7fff_ffff;
        end else if (v < $signed({{(WIDE_W-31){1'b1}}, {31{1'b0}}})) begin
            r = 32'h8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

/* sv/wsp_div.sv */
module wsp_div (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             en,
    input  logic             in_valid,
    input  wsp_pkg::div_in_t in_data,
    output logic             out_valid,
    output wsp_pkg::div_out_t out_data
);
    import wsp_pkg::*;

    // Restoring division of num * 2^16 by den, one quotient bit per stage.
    logic [CLIP_W-1:0]  rem_reg  [0:QUO_W][LANES];
    logic [CLIP_W-1:0]  rem_next [0:QUO_W][LANES];
    logic [ABS_W-1:0]   num_reg  [0:QUO_W][LANES];
    logic [ABS_W-1:0]   num_next [0:QUO_W][LANES];
    logic [QUO_W-1:0]   quo_reg  [0:QUO_W][LANES];
    logic [QUO_W-1:0]   quo_next [0:QUO_W][LANES];
    logic [ABS_W-1:0]   den_reg  [0:QUO_W];
    logic [ABS_W-1:0]   den_next [0:QUO_W];
    logic [LANES-1:0]   ovf_reg  [0:QUO_W];
    logic [LANES-1:0]   ovf_next [0:QUO_W];
    div_side_t          side_reg [0:QUO_W];
    div_side_t          side_next[0:QUO_W];
    logic [QUO_W:0]     vld_reg;

    always_comb begin
        logic [ABS_W+15:0] dvd;
        logic [CLIP_W-1:0] t;
        logic              ge;
        logic [QUO_W-1:0]  q;
        den_next[0]  = in_data.den;
        side_next[0] = in_data.side;
        for (int l = 0; l < LANES; l++) begin
            num_next[0][l] = in_data.num[l];
            rem_next[0][l] = {{(CLIP_W-17){1'b0}}, in_data.num[l][ABS_W-1:32]};
            quo_next[0][l] = '0;
            ovf_next[0][l] = {{(ABS_W-17){1'b0}}, in_data.num[l][ABS_W-1:32]} >= in_data.den;
        end
        for (int k = 1; k <= QUO_W; k++) begin
            den_next[k]  = den_reg[k-1];
            side_next[k] = side_reg[k-1];
            ovf_next[k]  = ovf_reg[k-1];
            for (int l = 0; l < LANES; l++) begin
                dvd = {num_reg[k-1][l], 16'b0};
                t   = {rem_reg[k-1][l][ABS_W-1:0], dvd[QUO_W-k]};
                ge  = t >= {1'b0, den_reg[k-1]};
                q   = quo_reg[k-1][l];
                q[QUO_W-k] = ge;
                rem_next[k][l] = ge ? t - {1'b0, den_reg[k-1]} : t;
                quo_next[k][l] = q;
                num_next[k][l] = num_reg[k-1][l];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k <= QUO_W; k++) begin
                den_reg[k]  <= den_next[k];
                side_reg[k] <= side_next[k];
                ovf_reg[k]  <= ovf_next[k];
                for (int l = 0; l < LANES; l++) begin
                    rem_reg[k][l] <= rem_next[k][l];
                    num_reg[k][l] <= num_next[k][l];
                    quo_reg[k][l] <= quo_next[k][l];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[QUO_W-1:0], in_valid};
        end
    end

    assign out_valid = vld_reg[QUO_W];

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            out_data.quo[l] = quo_reg[QUO_W][l];
        end
        out_data.ovf  = ovf_reg[QUO_W];
        out_data.side = side_reg[QUO_W];
    end

endmodule

/* sv/world_to_screen_projection.sv */
// Channel   | Direction | Payload
// s_        | in        | tdata: world_x, world_y, world_z (96 bits)
// m_        | out       | tdata: screen_x, screen_y, depth_ndc (96 bits); tuser: w_zero
// cfg_      | in        | cfg_addr selects one of six 64-bit registers, cfg_data
//
// One point enters per cycle while the output is not stalled; each point passes
// the transform, magnitude, 48-stage quotient pipeline and viewport stages.
// Reset is synchronous and active low; it clears the valid bits and loads the
// register defaults. When a result is held on the output, the whole pipeline
// holds and s_tready falls until the transfer completes.
module world_to_screen_projection (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [95:0] s_tdata,   // world_x, world_y, world_z
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [95:0] m_tdata,   // screen_x, screen_y, depth_ndc
    output logic [0:0]  m_tuser,   // w_zero
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_addr,
    input  logic [63:0] cfg_data
);
    import wsp_pkg::*;

    logic [63:0] row_reg [LANES];
    logic [63:0] trans_low_reg;
    logic [63:0] trans_high_reg;
    logic [63:0] viewport_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int l = 0; l < LANES; l++) begin
                row_reg[l] <= '0;
            end
            trans_low_reg  <= '0;
            trans_high_reg <= 64'h0000_0001_0000_0000;
            viewport_reg   <= '0;
        end else if (cfg_wr_en) begin
            case (reg_index_t'(cfg_addr))
                REG_ROW_X:      row_reg[0]     <= cfg_data;
                REG_ROW_Y:      row_reg[1]     <= cfg_data;
                REG_ROW_Z:      row_reg[2]     <= cfg_data;
                REG_TRANS_LOW:  trans_low_reg  <= cfg_data;
                REG_TRANS_HIGH: trans_high_reg <= cfg_data;
                REG_VIEWPORT:   viewport_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    logic [15:0] vp_x, vp_y, vp_w, vp_h;
    assign vp_x = viewport_reg[15:0];
    assign vp_y = viewport_reg[31:16];
    assign vp_w = viewport_reg[47:32];
    assign vp_h = viewport_reg[63:48];

    logic en;
    logic m_tvalid_reg;
    assign en       = !m_tvalid_reg || m_tready;
    assign s_tready = en;

    // Input register.
    logic signed [31:0] pt_reg [LANES];
    logic               s0_vld_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int l = 0; l < LANES; l++) begin
                pt_reg[l] <= s_tdata[32*l +: 32];
            end
        end
    end

    // Products: coefficient of row i, column j times point component i.
    logic signed [47:0] prod_reg  [LANES][4];
    logic signed [42:0] tshift_reg[4];
    logic               s1_vld_reg;

    always_ff @(posedge aclk) begin
        logic [127:0] tr;
        tr = {trans_high_reg, trans_low_reg};
        if (en) begin
            for (int i = 0; i < LANES; i++) begin
                for (int j = 0; j < 4; j++) begin
                    prod_reg[i][j] <= pt_reg[i] * $signed(row_reg[i][16*j +: 16]);
                end
            end
            for (int j = 0; j < 4; j++) begin
                tshift_reg[j] <= {tr[32*j +: 32], 11'b0};
            end
        end
    end

    // Clip coordinates, scale 2^-27.
    logic signed [CLIP_W-1:0] clip_reg [4];
    logic                     s2_vld_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int j = 0; j < 4; j++) begin
                clip_reg[j] <= CLIP_W'(prod_reg[0][j]) + CLIP_W'(prod_reg[1][j])
                             + CLIP_W'(prod_reg[2][j]) + CLIP_W'(tshift_reg[j]);
            end
        end
    end

    // Magnitudes and signs for the divider.
    div_in_t s3_reg;
    logic    s3_vld_reg;

    always_ff @(posedge aclk) begin
        logic [CLIP_W-1:0] a;
        logic              dn;
        if (en) begin
            dn = clip_reg[3][CLIP_W-1];
            a  = dn ? CLIP_W'(-clip_reg[3]) : clip_reg[3];
            s3_reg.den         <= a[ABS_W-1:0];
            s3_reg.side.w_zero <= (clip_reg[3] == '0);
            for (int l = 0; l < LANES; l++) begin
                a = clip_reg[l][CLIP_W-1] ? CLIP_W'(-clip_reg[l]) : clip_reg[l];
                s3_reg.num[l]      <= a[ABS_W-1:0];
                s3_reg.side.neg[l] <= clip_reg[l][CLIP_W-1] != dn;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s0_vld_reg <= 1'b0;
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
        end else if (en) begin
            s0_vld_reg <= s_tvalid;
            s1_vld_reg <= s0_vld_reg;
            s2_vld_reg <= s1_vld_reg;
            s3_vld_reg <= s2_vld_reg;
        end
    end

    logic     div_vld;
    div_out_t div_out;

    wsp_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s3_vld_reg),
        .in_data   (s3_reg),
        .out_valid (div_vld),
        .out_data  (div_out)
    );

    // Capped, signed NDC values in Q32.16.
    logic signed [ABS_W-1:0] ndc_reg [LANES];
    logic                    e1_wz_reg;
    logic                    e1_vld_reg;

    always_ff @(posedge aclk) begin
        logic [QUO_W-1:0] qc;
        if (en) begin
            e1_wz_reg <= div_out.side.w_zero;
            for (int l = 0; l < LANES; l++) begin
                qc = div_out.quo[l];
                if (div_out.ovf[l] || (qc[QUO_W-1] && (qc[QUO_W-2:0] != '0))) begin
                    qc = NDC_CAP;
                end
                ndc_reg[l] <= div_out.side.neg[l] ? -$signed({1'b0, qc})
                                                  : $signed({1'b0, qc});
            end
        end
    end

    // (ndc + 1.0) times viewport size for x and y; depth passes through.
    logic signed [66:0]      scl_reg [2];
    logic signed [ABS_W-1:0] e2_nz_reg;
    logic                    e2_wz_reg;
    logic                    e2_vld_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            scl_reg[0] <= ($signed((ABS_W+1)'(ndc_reg[0])) + 50'sd65536)
                          * $signed({1'b0, vp_w});
            scl_reg[1] <= ($signed((ABS_W+1)'(ndc_reg[1])) + 50'sd65536)
                          * $signed({1'b0, vp_h});
            e2_nz_reg  <= ndc_reg[2];
            e2_wz_reg  <= e1_wz_reg;
        end
    end

    // Halve, offset and flip.
    logic signed [WIDE_W-1:0] sx_reg, sy_reg, sz_reg;
    logic                     e3_wz_reg;
    logic                     e3_vld_reg;

    always_ff @(posedge aclk) begin
        logic signed [WIDE_W-1:0] hy;
        if (en) begin
            sx_reg <= (WIDE_W'(scl_reg[0]) >>> 1)
                    + $signed({{(WIDE_W-32){1'b0}}, vp_x, 16'b0});
            hy      = (WIDE_W'(scl_reg[1]) >>> 1)
                    + $signed({{(WIDE_W-32){1'b0}}, vp_y, 16'b0});
            sy_reg <= $signed({{(WIDE_W-32){1'b0}}, vp_h, 16'b0}) - hy;
            sz_reg <= WIDE_W'(e2_nz_reg);
            e3_wz_reg <= e2_wz_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            e1_vld_reg <= 1'b0;
            e2_vld_reg <= 1'b0;
            e3_vld_reg <= 1'b0;
        end else if (en) begin
            e1_vld_reg <= div_vld;
            e2_vld_reg <= e1_vld_reg;
            e3_vld_reg <= e2_vld_reg;
        end
    end

    // Output register with saturation.
    logic [95:0] out_data_reg;
    logic        out_wz_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            out_wz_reg <= e3_wz_reg;
            if (e3_wz_reg) begin
                out_data_reg <= '0;
            end else begin
                out_data_reg <= {sat32(sz_reg), sat32(sy_reg), sat32(sx_reg)};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            m_tvalid_reg <= e3_vld_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_wz_reg;

endmodule

/* sv/wsp_checker.sv */
`include "world_to_screen_projection_macros.svh"

module wsp_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [95:0] m_tdata,
    input logic [0:0]  m_tuser
);

    `WSP_ASSERT_NEXT(a_hold_valid, aclk, aresetn, m_tvalid && !m_tready, m_tvalid, "result withdrawn before transfer")

    `WSP_ASSERT_NEXT(a_hold_data, aclk, aresetn, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

    `WSP_ASSERT_NOW(a_wzero_clear, aclk, aresetn, m_tvalid && m_tuser[0], m_tdata == 96'd0, "zero w result carries nonzero data")

    `WSP_ASSERT_NOW(a_ready_when_empty, aclk, aresetn, !m_tvalid || m_tready, s_tready, "input stalled with free output")

endmodule

bind world_to_screen_projection wsp_checker u_wsp_checker (.*);

/* tb/tb_world_to_screen_projection.sv */
module tb_world_to_screen_projection;
    timeunit 1ns;
    timeprecision 1ps;

    import wsp_pkg::*;

    localparam int LATENCY     = 57;
    localparam int CYCLE_LIMIT = 1_000_000;

    typedef struct packed {
        logic [31:0] wz;
        logic [31:0] wy;
        logic [31:0] wx;
    } point_t;

    typedef struct packed {
        logic        w_zero;
        logic [31:0] depth;
        logic [31:0] sy;
        logic [31:0] sx;
    } pixel_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [95:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [95:0] m_tdata;
    logic [0:0]  m_tuser;
    logic        cfg_wr_en = 1'b0;
    logic [2:0]  cfg_addr = '0;
    logic [63:0] cfg_data = '0;

    world_to_screen_projection dut (.*);

    always #1 aclk = ~aclk;

    // Predictor copy of the registers.
    logic [63:0] regs [6];

    point_t pending_points[$];
    pixel_t expected_pixels[$];
    int     send_idle_pct = 0;
    int     recv_stall_pct = 0;
    int     errors = 0;
    int     pixels_seen = 0;
    int     flagged_seen = 0;
    longint cycles = 0;

    function automatic longint signed coef(int row, int col);
        logic [15:0] c;
        c = regs[row][16*col +: 16];
        return longint'($signed(c));
    endfunction

    function automatic longint signed trans(int col);
        logic [31:0] t;
        t = (col < 2) ? regs[REG_TRANS_LOW][32*(col & 1) +: 32]
                      : regs[REG_TRANS_HIGH][32*(col & 1) +: 32];
        return longint'($signed(t));
    endfunction

    // n * 2^16 / d, truncated toward zero, magnitude capped at 2^47.
    function automatic longint signed ndc_ratio(longint signed n, longint signed d);
        logic        neg;
        logic [63:0] un, ud, q0, r, q;
        neg = (n < 0) != (d < 0);
        un = (n < 0) ? -n : n;
        ud = (d < 0) ? -d : d;
        q0 = un / ud;
        r  = un % ud;
        if (q0 >= 64'h8000_0000) begin
            q = 64'h8000_0000_0000;
        end else begin
            q = q0 << 16;
            for (int i = 15; i >= 0; i--) begin
                r = r << 1;
                if (r >= ud) begin
                    r = r - ud;
                    q[i] = 1'b1;
                end
            end
            if (q > 64'h8000_0000_0000) q = 64'h8000_0000_0000;
        end
        return neg ? -longint'(q) : longint'(q);
    endfunction

    function automatic logic [31:0] clamp32(longint signed v);
        if (v > 64'sh7fff_ffff) return 32'h7fff_ffff;
        if (v < -64'sh8000_0000) return 32'h8000_0000;
        return v[31:0];
    endfunction

    function automatic longint signed floor_half(longint signed v);
        return v >>> 1;
    endfunction

    function automatic pixel_t project_point(point_t p);
        longint signed clip [4];
        longint signed px, py, pz, vx, vy, vw, vh, nx, ny, nz, sx, sy;
        pixel_t r;
        px = longint'($signed(p.wx));
        py = longint'($signed(p.wy));
        pz = longint'($signed(p.wz));
        vx = regs[REG_VIEWPORT][15:0];
        vy = regs[REG_VIEWPORT][31:16];
        vw = regs[REG_VIEWPORT][47:32];
        vh = regs[REG_VIEWPORT][63:48];
        for (int j = 0; j < 4; j++)
            clip[j] = px * coef(0, j) + py * coef(1, j) + pz * coef(2, j) + trans(j) * 2048;
        r = '0;
        if (clip[3] == 0) begin
            r.w_zero = 1'b1;
            return r;
        end
        nx = ndc_ratio(clip[0], clip[3]);
        ny = ndc_ratio(clip[1], clip[3]);
        nz = ndc_ratio(clip[2], clip[3]);
        sx = floor_half((nx + 65536) * vw) + vx * 65536;
        sy = vh * 65536 - (floor_half((ny + 65536) * vh) + vy * 65536);
        r.sx = clamp32(sx);
        r.sy = clamp32(sy);
        r.depth = clamp32(nz);
        return r;
    endfunction

    // Driver: presents the queue head and predicts on each accepted transfer.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                expected_pixels.push_back(project_point(point_t'(s_tdata)));
                void'(pending_points.pop_front());
            end
            if ((!s_tvalid || s_tready) &&
                (pending_points.size() > (s_tvalid && s_tready ? 0 : 0))) begin
                if (pending_points.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= pending_points[0];
                end else begin
                    s_tvalid <= 1'b0;
                end
            end else if (!s_tvalid || s_tready) begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Monitor: compares each result transfer with the oldest expectation.
    always @(posedge aclk) begin
        pixel_t got, want;
        if (aresetn) begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
            if (m_tvalid && m_tready) begin
                got = {m_tuser[0], m_tdata};
                pixels_seen++;
                if (got.w_zero) flagged_seen++;
                if (expected_pixels.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result %h", $time, got);
                end else begin
                    want = expected_pixels.pop_front();
                    if (got.sx !== want.sx) begin
                        errors++;
                        $display("%0t: screen_x expected %h actual %h", $time, want.sx, got.sx);
                    end
                    if (got.sy !== want.sy) begin
                        errors++;
                        $display("%0t: screen_y expected %h actual %h", $time, want.sy, got.sy);
                    end
                    if (got.depth !== want.depth) begin
                        errors++;
                        $display("%0t: depth_ndc expected %h actual %h", $time,
                                 want.depth, got.depth);
                    end
                    if (got.w_zero !== want.w_zero) begin
                        errors++;
                        $display("%0t: w_zero expected %b actual %b", $time,
                                 want.w_zero, got.w_zero);
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles", cycles);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic write_reg(reg_index_t idx, logic [63:0] value);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_data  <= value;
        regs[idx] = value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic drain();
        while (pending_points.size() > 0 || s_tvalid || expected_pixels.size() > 0)
            @(posedge aclk);
        repeat (LATENCY + 4) @(posedge aclk);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [31:0] rand_word();
        case ($urandom_range(5))
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2: return 32'h0;
            3: return $urandom;
            default: return $signed($urandom_range(0, 32'h00ff_ffff)) - 32'sh0080_0000;
        endcase
    endfunction

    // A Q4.11 coefficient row: mostly moderate values, sometimes extreme.
    function automatic logic [63:0] rand_row();
        logic [63:0] r;
        for (int c = 0; c < 4; c++)
            r[16*c +: 16] = ($urandom_range(3) == 0) ? 16'($urandom)
                                                      : 16'($urandom_range(0, 4096) - 2048);
        return r;
    endfunction

    function automatic point_t rand_point();
        return '{wz: rand_word(), wy: rand_word(), wx: rand_word()};
    endfunction

    initial begin
        regs[REG_ROW_X]      = '0;
        regs[REG_ROW_Y]      = '0;
        regs[REG_ROW_Z]      = '0;
        regs[REG_TRANS_LOW]  = '0;
        regs[REG_TRANS_HIGH] = 64'h1_0000_0000;
        regs[REG_VIEWPORT]   = '0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset defaults: clip w is 2^-16 and the viewport is zero, so every point lands on the origin.
        pending_points.push_back('{wz: 32'h7fff_ffff, wy: 32'h8000_0000, wx: 32'h0001_0000});
        drain();

        // Identity-like camera with perspective from z, 640x480 viewport.
        write_reg(REG_ROW_X, 64'h0000_0000_0000_0800);
        write_reg(REG_ROW_Y, 64'h0000_0000_0800_0000);
        write_reg(REG_ROW_Z, 64'h0800_0000_0000_0000);
        write_reg(REG_TRANS_LOW, 64'h0);
        write_reg(REG_TRANS_HIGH, 64'h0);
        write_reg(REG_VIEWPORT, {16'd480, 16'd640, 16'd10, 16'd20});
        // Zero w (z = 0), ordinary points, a huge ratio and the field extremes.
        pending_points.push_back('{wz: 32'h0, wy: 32'h0001_0000, wx: 32'h0001_0000});
        pending_points.push_back('{wz: 32'h0002_0000, wy: 32'h0001_0000, wx: 32'hffff_0000});
        pending_points.push_back('{wz: 32'h0000_0001, wy: 32'h7fff_ffff, wx: 32'h8000_0000});
        pending_points.push_back('{wz: 32'hffff_ffff, wy: 32'h8000_0000, wx: 32'h7fff_ffff});
        pending_points.push_back('{wz: 32'h8000_0000, wy: 32'h8000_0000, wx: 32'h8000_0000});
        pending_points.push_back('{wz: 32'h7fff_ffff, wy: 32'h7fff_ffff, wx: 32'h7fff_ffff});
        pending_points.push_back('{wz: 32'hffff_0000, wy: 32'h0000_8000, wx: 32'h0000_8000});
        drain();

        // Extreme registers: all-ones, most negative and most positive rows, extreme translation, largest viewport.
        write_reg(REG_ROW_X, '1);
        write_reg(REG_ROW_Y, 64'h8000_8000_8000_8000);
        write_reg(REG_ROW_Z, 64'h7fff_7fff_7fff_7fff);
        write_reg(REG_TRANS_LOW, 64'h8000_0000_7fff_ffff);
        write_reg(REG_TRANS_HIGH, '1);
        write_reg(REG_VIEWPORT, '1);
        for (int i = 0; i < 8; i++) pending_points.push_back(rand_point());
        drain();

        // Random phases, each with a fresh camera and one of four idling patterns.
        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 73; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 73; end
                default: begin send_idle_pct = 22; recv_stall_pct = 22; end
            endcase
            write_reg(REG_ROW_X, rand_row());
            write_reg(REG_ROW_Y, rand_row());
            write_reg(REG_ROW_Z, rand_row());
            write_reg(REG_TRANS_LOW, rand64());
            write_reg(REG_TRANS_HIGH, ph == 7 ? 64'h0 : rand64());
            write_reg(REG_VIEWPORT, ph == 6 ? 64'h0 : rand64());
            for (int i = 0; i < 130; i++) pending_points.push_back(rand_point());
            drain();
        end

        $display("Projected %0d points through 11 camera settings, %0d with zero clip w.",
                 pixels_seen, flagged_seen);
        if (errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
